// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define PFCM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset
`define PFCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pfcm_pkg.sv -----
`timescale 1ns / 1ps

package pfcm_pkg;

    localparam logic [31:0] TARGET_RESET = 32'd5000000;
    localparam logic [31:0] WINDOW_RESET = 32'd100000000;
    localparam logic [63:0] FACE_OFFSET  = 64'd250;

    // Iteration counts of the shared subtractor
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;

    typedef enum logic [0:0] {
        REG_TARGET = 1'b0,
        REG_WINDOW = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [63:0] base_hop_rtt;
        logic [63:0] smoothed_delay;
        logic        checking;
        logic [63:0] first_above;
        logic [31:0] react_window;
        logic [31:0] loss_count;
    } face_entry_t;

    localparam face_entry_t ENTRY_RESET = '{
        base_hop_rtt:   64'hFFFF_FFFF_FFFF_FFFF,
        smoothed_delay: 64'd0,
        checking:       1'b0,
        first_above:    64'd0,
        react_window:   WINDOW_RESET,
        loss_count:     32'd0
    };

endpackage

// ----- sv/per_face_codel_congestion_marker.sv -----
// Per-face congestion marker for returning data packets.
// Request: raise start with the packet fields; it is taken at a rising edge with
// start high and busy low. busy stays high until the result is out.
// Result: done is high for exactly one cycle with rtt_out_ns, path_out, mark_loss
// and queue_delay_ns; the receiver must take it then, it cannot stall the block.
// Sequence: the block steps through HOP, LOAD, SAMPLE, DECIDE and WRITE and then
// raises done; a new request is taken in the done cycle. A face index out of
// range goes from HOP to WRITE. A marked loss adds one multiply, 64 divide steps
// and 32 square root steps on one shared 35-bit subtractor before WRITE.
// Per-face state sits in one memory of NUM_FACES entries read through a
// registered port; a valid bit per face makes an unwritten face read as reset.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_index (0 target
// delay, 1 initial reaction window) at once; write only while idle.
// Reset (rst_n low) clears all valid bits, restores both registers and returns
// the sequencer to idle; the block can take a request straight after release.
`timescale 1ns / 1ps

module per_face_codel_congestion_marker #(
    parameter int NUM_FACES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wr_data,
    input  logic [5:0]  face_index,
    input  logic [63:0] face_id,
    input  logic [63:0] now_ns,
    input  logic [63:0] last_sent_ns,
    input  logic [63:0] downstream_rtt_ns,
    input  logic [63:0] path_in,
    output logic        done,
    output logic [63:0] rtt_out_ns,
    output logic [63:0] path_out,
    output logic        mark_loss,
    output logic [63:0] queue_delay_ns
);

    localparam int AW = (NUM_FACES > 1) ? $clog2(NUM_FACES) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HOP,
        S_LOAD,
        S_SAMPLE,
        S_DECIDE,
        S_MUL,
        S_DIV,
        S_SQRT,
        S_WRITE
    } state_t;

    state_t                state_reg;
    logic [31:0]           target_reg;
    logic [31:0]           init_win_reg;
    logic [NUM_FACES-1:0]  valid_reg;
    logic                  rd_valid_reg;
    pfcm_pkg::face_entry_t rd_data_reg;
    pfcm_pkg::face_entry_t mem [NUM_FACES];

    logic [AW-1:0] addr_reg;
    logic          in_range_reg;
    logic [63:0]   now_reg;
    logic [63:0]   down_reg;
    logic [63:0]   rtt_reg;
    logic [63:0]   path_reg;
    logic [63:0]   hop_reg;
    logic [63:0]   base_reg;
    logic [63:0]   smooth_reg;
    logic          chk_reg;
    logic [63:0]   first_reg;
    logic [31:0]   win_reg;
    logic [31:0]   loss_reg;
    logic [63:0]   sample_reg;
    logic [63:0]   elapsed_reg;
    logic          mark_reg;
    logic [5:0]    cnt_reg;
    logic [32:0]   rem_reg;
    logic [63:0]   quo_reg;
    logic [31:0]   root_reg;

    logic [34:0]   alu_a;
    logic [34:0]   alu_b;
    logic [35:0]   alu_diff;
    logic          alu_ge;

    pfcm_pkg::face_entry_t entry;
    pfcm_pkg::face_entry_t wr_entry;
    logic [63:0]           sample;
    logic [63:0]           qd;
    logic                  above;
    logic                  mem_we;

    // Shared subtractor: divide step or square root step
    always_comb
    begin
        case (state_reg)
            S_DIV:
            begin
                alu_a = 35'({rem_reg[31:0], quo_reg[63]});
                alu_b = 35'(loss_reg);
            end
            S_SQRT:
            begin
                alu_a = {rem_reg, quo_reg[63:62]};
                alu_b = 35'({root_reg, 2'b01});
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
        alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
        alu_ge   = !alu_diff[35];
    end

    // Face entry as read, sample and smoothed delay
    always_comb
    begin
        entry  = rd_valid_reg ? rd_data_reg : pfcm_pkg::ENTRY_RESET;
        sample = hop_reg - base_reg;
        qd     = (sample >> 1) + (smooth_reg >> 1) + 64'(sample[0] & smooth_reg[0]);
        above  = sample_reg >= 64'(target_reg);
        mem_we = (state_reg == S_WRITE) && in_range_reg;
        // A marked loss stores the shrunk window
        wr_entry = '{
            base_hop_rtt:   base_reg,
            smoothed_delay: smooth_reg,
            checking:       chk_reg,
            first_above:    first_reg,
            react_window:   mark_reg ? root_reg : win_reg,
            loss_count:     loss_reg
        };
    end

    // Per-face state memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= wr_entry;
        end
        if (state_reg == S_HOP)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    // Sequencer, configuration and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            target_reg   <= pfcm_pkg::TARGET_RESET;
            init_win_reg <= pfcm_pkg::WINDOW_RESET;
            valid_reg    <= '0;
            done         <= 1'b0;
        end
        else
        begin
            done <= (state_reg == S_WRITE);

            // Take configuration writes
            if (cfg_wr_en)
            begin
                if (cfg_index == pfcm_pkg::REG_TARGET)
                begin
                    target_reg <= cfg_wr_data;
                end
                else
                begin
                    init_win_reg <= cfg_wr_data;
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        addr_reg     <= AW'(face_index);
                        in_range_reg <= 32'(face_index) < NUM_FACES;
                        now_reg      <= now_ns;
                        down_reg     <= downstream_rtt_ns;
                        rtt_reg      <= now_ns - last_sent_ns;
                        path_reg     <= {path_in[57:0],
                                         face_id[5:0] - pfcm_pkg::FACE_OFFSET[5:0]};
                        mark_reg     <= 1'b0;
                        state_reg    <= S_HOP;
                    end
                end
                S_HOP:
                begin
                    hop_reg      <= rtt_reg - down_reg;
                    rd_valid_reg <= valid_reg[addr_reg];
                    state_reg    <= in_range_reg ? S_LOAD : S_WRITE;
                end
                S_LOAD:
                begin
                    base_reg   <= (hop_reg < entry.base_hop_rtt) ? hop_reg
                                                                  : entry.base_hop_rtt;
                    smooth_reg <= entry.smoothed_delay;
                    chk_reg    <= entry.checking;
                    first_reg  <= entry.first_above;
                    win_reg    <= entry.react_window;
                    loss_reg   <= entry.loss_count;
                    state_reg  <= S_SAMPLE;
                end
                S_SAMPLE:
                begin
                    sample_reg  <= sample;
                    smooth_reg  <= qd;
                    elapsed_reg <= now_reg - first_reg;
                    state_reg   <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (above)
                    begin
                        if (!chk_reg)
                        begin
                            first_reg <= now_reg;
                            chk_reg   <= 1'b1;
                            state_reg <= S_WRITE;
                        end
                        else if (elapsed_reg > 64'(win_reg))
                        begin
                            // Mark a loss, restart the window, then shrink it
                            mark_reg  <= 1'b1;
                            first_reg <= now_reg;
                            if (loss_reg != '1)
                            begin
                                loss_reg <= loss_reg + 32'd1;
                            end
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            state_reg <= S_WRITE;
                        end
                    end
                    else
                    begin
                        chk_reg   <= 1'b0;
                        loss_reg  <= '0;
                        win_reg   <= init_win_reg;
                        state_reg <= S_WRITE;
                    end
                end
                S_MUL:
                begin
                    quo_reg   <= 64'(win_reg) * 64'(win_reg);
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    // One quotient bit a cycle
                    quo_reg <= {quo_reg[62:0], alu_ge};
                    if (cnt_reg == 6'(pfcm_pkg::DIV_STEPS - 1))
                    begin
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        rem_reg <= alu_ge ? 33'(alu_diff) : 33'(alu_a);
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_SQRT:
                begin
                    // One root bit a cycle, two radicand bits consumed
                    rem_reg  <= alu_ge ? 33'(alu_diff) : 33'(alu_a);
                    root_reg <= {root_reg[30:0], alu_ge};
                    quo_reg  <= {quo_reg[61:0], 2'b00};
                    cnt_reg  <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(pfcm_pkg::SQRT_STEPS - 1))
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (in_range_reg)
                    begin
                        valid_reg[addr_reg] <= 1'b1;
                    end
                    rtt_out_ns     <= rtt_reg;
                    path_out       <= path_reg;
                    mark_loss      <= mark_reg;
                    queue_delay_ns <= in_range_reg ? smooth_reg : 64'd0;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- sv/pfcm_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pfcm_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // A taken request holds the block busy
    `PFCM_ASSERT_NEXT(a_req_busy, start && !busy, busy, "request taken but not busy")
    // A result appears only once the block has released
    `PFCM_ASSERT_SAME(a_done_idle, done, !busy, "result while busy")
    // A result strobe lasts one cycle
    `PFCM_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held")
    // Leaving busy always delivers a result
    `PFCM_ASSERT_SAME(a_fall_done, $fell(busy), done, "busy dropped without result")

endmodule

bind per_face_codel_congestion_marker pfcm_checker u_pfcm_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
